[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while the synchronous reset is low.
`define CHK_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Assertion that is also evaluated while reset is applied.
`define CHK_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

[rtl/core/gacf_pkg.sv]
// ----------------------------------------------------------------------------
// gacf_pkg
// Types, constants and tables of the gyro and accelerometer angle filter.
// ----------------------------------------------------------------------------
`default_nettype none

package gacf_pkg;

    // Number of CORDIC micro-rotations; the angle table is sized for 24 entries and lists values for 0 to 16.
    localparam int CORDIC_STEPS = 16;
    localparam int AtanLen      = 24;
    localparam int CordicIters  = (CORDIC_STEPS > AtanLen) ? AtanLen : CORDIC_STEPS;
    localparam int IterW        = $clog2(CordicIters);
    localparam int ShiftW       = $clog2(AtanLen);

    // Datapath widths.
    localparam int XyW   = 32;
    localparam int ZW    = 21;
    localparam int MulW  = 24;
    localparam int ProdW = 2 * MulW + 1;
    localparam int AccW  = 64;
    localparam int DiffW = 34;
    localparam int HalfW = DiffW / 2;
    localparam int MagW  = 38;
    localparam int MagLoW = 19;
    localparam int DeltaW = 30;

    // Input field widths.
    localparam int RateW  = 22;
    localparam int AccelW = 15;
    localparam int MsW    = 16;
    localparam int CoeffW = 17;
    localparam int AngleW = 32;

    // Millidegrees per second times milliseconds to Q16.16 radians, scaled by 2^32.
    localparam logic [22:0] GyroK = 23'd4912665;
    localparam logic signed [ZW-1:0] PiQ16 = 21'sd205887;
    localparam logic [CoeffW-1:0] CoeffOne = 17'd65536;
    localparam logic [CoeffW-1:0] CoeffReset = 17'd62259;
    localparam int AccelPreShift = 14;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CORDIC,
        S_GMUL,
        S_GABS,
        S_GLO,
        S_GHI,
        S_GSUM,
        S_PRED,
        S_BLO,
        S_BHI,
        S_BSUM,
        S_DONE
    } t_state;

    // round(atan(2^-i) * 65536).
    function automatic logic [15:0] atan_q16(input logic [ShiftW-1:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30386;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/core/gyro_accel_complementary_filter.sv]
// ----------------------------------------------------------------------------
// gyro_accel_complementary_filter
// Complementary filter that fuses an integrated gyro rate with an
// accelerometer tilt angle and outputs the kept angle in Q16.16 radians.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_ready    gyro rate, accel x/y, ms
//   output    out        o_out_valid / i_out_ready  o_angle_q16
//   config    in         i_cfg_we                   i_cfg_wdata (blend coeff)
//
// A new word is taken only in the idle state, once the last word has run
// through 16 CORDIC micro-rotations on the shared add/shift unit, nine
// sequencer steps that run the gyro and blend products through the shared
// 24-bit multiplier, and the load of the result.
// Reset is synchronous and active low; it clears the kept angle, restores
// the blend coefficient and empties the output register.
// A stalled output holds its word; the next input word is still taken, and
// only the final load waits for the output register to free up.
// ----------------------------------------------------------------------------
`default_nettype none

module gyro_accel_complementary_filter (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic signed [gacf_pkg::RateW-1:0]      i_gyro_rate_mdps,
    input  wire logic signed [gacf_pkg::AccelW-1:0]     i_accel_x_mg,
    input  wire logic signed [gacf_pkg::AccelW-1:0]     i_accel_y_mg,
    input  wire logic        [gacf_pkg::MsW-1:0]        i_elapsed_ms,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic signed [gacf_pkg::AngleW-1:0]          o_angle_q16,
    input  wire logic                                   i_cfg_we,
    input  wire logic        [gacf_pkg::CoeffW-1:0]     i_cfg_wdata
);

    localparam int AccW_DELTA_HI = 32 + gacf_pkg::DeltaW - 1;

    // Sequencer state and control registers.
    gacf_pkg::t_state r_state, n_state;
    logic [gacf_pkg::IterW-1:0] r_cnt, n_cnt;
    logic r_out_valid, n_out_valid;
    logic [gacf_pkg::CoeffW-1:0] r_blend_coeff;
    logic signed [gacf_pkg::AngleW-1:0] r_angle, n_angle;

    // Payload registers.
    logic signed [gacf_pkg::RateW-1:0] r_rate, n_rate;
    logic [gacf_pkg::MsW-1:0] r_ms, n_ms;
    logic signed [gacf_pkg::XyW-1:0] r_x, n_x, r_y, n_y;
    logic signed [gacf_pkg::ZW-1:0] r_z, n_z;
    logic r_tilt_zero, n_tilt_zero;
    logic signed [gacf_pkg::ProdW-1:0] r_prod, n_prod;
    logic r_neg, n_neg;
    logic [gacf_pkg::MagW-1:0] r_mag, n_mag;
    logic signed [gacf_pkg::AccW-1:0] r_acc, n_acc;
    logic signed [gacf_pkg::DiffW-1:0] r_diff, n_diff;
    logic signed [gacf_pkg::AngleW-1:0] r_out, n_out;

    // Shared multiplier.
    logic signed [gacf_pkg::MulW-1:0] mul_a;
    logic [gacf_pkg::MulW-1:0] mul_b;
    logic signed [gacf_pkg::ProdW-1:0] mul_p;

    // CORDIC add/shift unit.
    logic [gacf_pkg::ShiftW-1:0] shamt;
    logic signed [gacf_pkg::XyW-1:0] sx, sy;
    logic signed [gacf_pkg::ZW-1:0] atan_step;

    // Input pre-rotation.
    logic signed [gacf_pkg::XyW-1:0] x0, y0;
    logic in_accept;

    // Misc datapath wires.
    logic [gacf_pkg::CoeffW-1:0] coeff_eff;
    logic signed [gacf_pkg::ZW-1:0] tilt;
    logic signed [gacf_pkg::DiffW-1:0] sdelta;
    logic [gacf_pkg::DeltaW-1:0] delta_mag;
    logic signed [gacf_pkg::ProdW-1:0] prod_abs;
    logic signed [gacf_pkg::AccW-gacf_pkg::AngleW/2-1:0] res_wide;
    logic signed [gacf_pkg::AngleW-1:0] res_sat;
    logic out_free;

    assign in_accept = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == gacf_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_angle_q16 = r_out;
    assign out_free = !r_out_valid || i_out_ready;

    // A coefficient above one acts as exactly one.
    assign coeff_eff = (r_blend_coeff > gacf_pkg::CoeffOne) ? gacf_pkg::CoeffOne
                                                           : r_blend_coeff;

    // With both axes zero the tilt is defined as zero.
    assign tilt = r_tilt_zero ? '0 : r_z;

    // The axes are scaled by 2^14 so the CORDIC keeps fractional precision.
    assign x0 = gacf_pkg::XyW'(i_accel_x_mg) <<< gacf_pkg::AccelPreShift;
    assign y0 = gacf_pkg::XyW'(i_accel_y_mg) <<< gacf_pkg::AccelPreShift;

    assign shamt = gacf_pkg::ShiftW'(r_cnt);
    assign sx = r_x >>> shamt;
    assign sy = r_y >>> shamt;
    assign atan_step = $signed(gacf_pkg::ZW'(gacf_pkg::atan_q16(shamt)));

    assign mul_p = mul_a * $signed({1'b0, mul_b});

    assign prod_abs = r_prod[gacf_pkg::ProdW-1] ? -r_prod : r_prod;
    assign delta_mag = r_acc[AccW_DELTA_HI:32];
    assign sdelta = r_neg ? -$signed(gacf_pkg::DiffW'(delta_mag))
                          : $signed(gacf_pkg::DiffW'(delta_mag));

    // Final rounding shift and saturation to the signed 32-bit range.
    assign res_wide = r_acc[gacf_pkg::AccW-1:gacf_pkg::AngleW/2];
    always_comb begin
        if (res_wide > $signed(gacf_pkg::AccW'({1'b0, {(gacf_pkg::AngleW-1){1'b1}}}))) begin
            res_sat = {1'b0, {(gacf_pkg::AngleW-1){1'b1}}};
        end else if (res_wide < -$signed(gacf_pkg::AccW'({1'b1, {(gacf_pkg::AngleW-1){1'b0}}}))) begin
            res_sat = {1'b1, {(gacf_pkg::AngleW-1){1'b0}}};
        end else begin
            res_sat = res_wide[gacf_pkg::AngleW-1:0];
        end
    end

    // Operand selection for the shared multiplier. The 38-bit gyro product
    // and the 34-bit blend difference are each split into two halves.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            gacf_pkg::S_GMUL: begin
                mul_a = gacf_pkg::MulW'(r_rate);
                mul_b = gacf_pkg::MulW'(r_ms);
            end
            gacf_pkg::S_GLO: begin
                mul_a = $signed(gacf_pkg::MulW'(r_mag[gacf_pkg::MagLoW-1:0]));
                mul_b = gacf_pkg::MulW'(gacf_pkg::GyroK);
            end
            gacf_pkg::S_GHI: begin
                mul_a = $signed(gacf_pkg::MulW'(r_mag[gacf_pkg::MagW-1:gacf_pkg::MagLoW]));
                mul_b = gacf_pkg::MulW'(gacf_pkg::GyroK);
            end
            gacf_pkg::S_BLO: begin
                mul_a = $signed(gacf_pkg::MulW'(r_diff[gacf_pkg::HalfW-1:0]));
                mul_b = gacf_pkg::MulW'(coeff_eff);
            end
            gacf_pkg::S_BHI: begin
                mul_a = gacf_pkg::MulW'($signed(r_diff[gacf_pkg::DiffW-1:gacf_pkg::HalfW]));
                mul_b = gacf_pkg::MulW'(coeff_eff);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer: next state and next values of the datapath registers.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_angle     = r_angle;
        n_rate      = r_rate;
        n_ms        = r_ms;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_tilt_zero = r_tilt_zero;
        n_prod      = r_prod;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_acc       = r_acc;
        n_diff      = r_diff;
        n_out       = r_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            gacf_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_rate      = i_gyro_rate_mdps;
                    n_ms        = i_elapsed_ms;
                    n_cnt       = '0;
                    n_tilt_zero = (i_accel_x_mg == '0) && (i_accel_y_mg == '0);
                    // A vector in the left half-plane is turned by pi first.
                    if (i_accel_x_mg[gacf_pkg::AccelW-1]) begin
                        n_x = -x0;
                        n_y = -y0;
                        n_z = i_accel_y_mg[gacf_pkg::AccelW-1] ? -gacf_pkg::PiQ16
                                                               : gacf_pkg::PiQ16;
                    end else begin
                        n_x = x0;
                        n_y = y0;
                        n_z = '0;
                    end
                    n_state = gacf_pkg::S_CORDIC;
                end
            end
            gacf_pkg::S_CORDIC: begin
                if (!r_y[gacf_pkg::XyW-1]) begin
                    n_x = r_x + sy;
                    n_y = r_y - sx;
                    n_z = r_z + atan_step;
                end else begin
                    n_x = r_x - sy;
                    n_y = r_y + sx;
                    n_z = r_z - atan_step;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == gacf_pkg::IterW'(gacf_pkg::CordicIters - 1)) begin
                    n_state = gacf_pkg::S_GMUL;
                end
            end
            gacf_pkg::S_GMUL: begin
                n_prod  = mul_p;
                n_state = gacf_pkg::S_GABS;
            end
            gacf_pkg::S_GABS: begin
                // Rounding offset of one half before the shift by 32.
                n_neg   = r_prod[gacf_pkg::ProdW-1];
                n_mag   = prod_abs[gacf_pkg::MagW-1:0];
                n_acc   = gacf_pkg::AccW'(64'sh8000_0000);
                n_state = gacf_pkg::S_GLO;
            end
            gacf_pkg::S_GLO: begin
                n_prod  = mul_p;
                n_state = gacf_pkg::S_GHI;
            end
            gacf_pkg::S_GHI: begin
                n_acc   = r_acc + gacf_pkg::AccW'(r_prod);
                n_prod  = mul_p;
                n_state = gacf_pkg::S_GSUM;
            end
            gacf_pkg::S_GSUM: begin
                n_acc   = r_acc + (gacf_pkg::AccW'(r_prod) <<< gacf_pkg::MagLoW);
                n_state = gacf_pkg::S_PRED;
            end
            gacf_pkg::S_PRED: begin
                // coeff*pred + (1-coeff)*tilt is formed as coeff*(pred-tilt) + tilt.
                n_diff  = gacf_pkg::DiffW'(r_angle) + sdelta - gacf_pkg::DiffW'(tilt);
                n_state = gacf_pkg::S_BLO;
            end
            gacf_pkg::S_BLO: begin
                n_prod  = mul_p;
                n_acc   = (gacf_pkg::AccW'(tilt) <<< (gacf_pkg::AngleW / 2))
                          + gacf_pkg::AccW'(64'sd32768);
                n_state = gacf_pkg::S_BHI;
            end
            gacf_pkg::S_BHI: begin
                n_acc   = r_acc + gacf_pkg::AccW'(r_prod);
                n_prod  = mul_p;
                n_state = gacf_pkg::S_BSUM;
            end
            gacf_pkg::S_BSUM: begin
                n_acc   = r_acc + (gacf_pkg::AccW'(r_prod) <<< gacf_pkg::HalfW);
                n_state = gacf_pkg::S_DONE;
            end
            gacf_pkg::S_DONE: begin
                if (out_free) begin
                    n_out       = res_sat;
                    n_angle     = res_sat;
                    n_out_valid = 1'b1;
                    n_state     = gacf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gacf_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= gacf_pkg::S_IDLE;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
            r_angle       <= '0;
            r_blend_coeff <= gacf_pkg::CoeffReset;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_angle     <= n_angle;
            if (i_cfg_we) begin
                r_blend_coeff <= i_cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rate      <= n_rate;
        r_ms        <= n_ms;
        r_x         <= n_x;
        r_y         <= n_y;
        r_z         <= n_z;
        r_tilt_zero <= n_tilt_zero;
        r_prod      <= n_prod;
        r_neg       <= n_neg;
        r_mag       <= n_mag;
        r_acc       <= n_acc;
        r_diff      <= n_diff;
        r_out       <= n_out;
    end

endmodule

`default_nettype wire

[rtl/core/gacf_checker.sv]
// ----------------------------------------------------------------------------
// gacf_checker
// Port-level checks of the angle filter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gacf_checker (
    input wire logic                                   i_clk,
    input wire logic                                   i_rst_n,
    input wire logic                                   i_in_valid,
    input wire logic                                   o_in_ready,
    input wire logic                                   o_out_valid,
    input wire logic                                   i_out_ready,
    input wire logic signed [gacf_pkg::AngleW-1:0]     o_angle_q16
);

    // A word that waits on the output keeps its value.
    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_angle_q16))

    // After a word is taken the block is busy with it.
    `CHK_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready)

    // A new result is loaded only from the busy sequence.
    `CHK_ASSERT(a_result_from_busy, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(!o_in_ready))

    // Reset leaves an empty output and a ready input.
    `CHK_ASSERT_RST(a_reset_clean, i_clk, !i_rst_n |=> !o_out_valid && o_in_ready)

endmodule

bind gyro_accel_complementary_filter gacf_checker u_gacf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_angle_q16 (o_angle_q16)
);

`default_nettype wire
